FILE: src/ppm_hdr_pkg.sv
// Shared types, character codes and token update function for the PPM P6 header parser.
package ppm_hdr_pkg;

  localparam int unsigned MAX_TOKEN_CHARS = 5;

  localparam int unsigned LEN_W   = $clog2(MAX_TOKEN_CHARS + 1);
  localparam longint unsigned TOK_MAX = (64'd10 ** MAX_TOKEN_CHARS) - 64'd1;
  localparam int unsigned TOK_W   = $clog2(TOK_MAX + 1);
  localparam int unsigned DIM_W   = 17;
  localparam int unsigned MAXV_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PH_W    = 2;
  localparam int unsigned CMP_W   = (TOK_W > DIM_W) ? TOK_W : DIM_W;

  localparam logic [CMP_W-1:0] DIM_SAT      = CMP_W'(131071);
  localparam logic [CMP_W-1:0] MAXVAL_LIMIT = CMP_W'(65536);

  localparam logic [BYTE_W-1:0] CH_HASH  = 8'd35;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;
  localparam logic [BYTE_W-1:0] CH_P     = 8'd80;
  localparam logic [BYTE_W-1:0] CH_6     = 8'd54;

  localparam logic [PH_W-1:0] PH_MAGIC  = 2'd0;
  localparam logic [PH_W-1:0] PH_WIDTH  = 2'd1;
  localparam logic [PH_W-1:0] PH_HEIGHT = 2'd2;
  localparam logic [PH_W-1:0] PH_MAXVAL = 2'd3;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_MAGIC  = 3'd1,
    ST_BAD_WIDTH  = 3'd2,
    ST_BAD_HEIGHT = 3'd3,
    ST_BAD_MAXVAL = 3'd4
  } status_e;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [TOK_W-1:0] value;
    logic             invalid;
    logic             magic_ok;
  } tok_t;

  localparam tok_t TOK_CLEAR = '{len: '0, value: '0, invalid: 1'b0, magic_ok: 1'b1};

  typedef struct packed {
    status_e             status;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [MAXV_W-1:0]   maxv;
    logic [BYTE_W-1:0]   pixel;
  } res_t;

  function automatic logic is_space(logic [BYTE_W-1:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
  endfunction

  // one character into the current token
  function automatic tok_t take_char(tok_t tok, logic [PH_W-1:0] phase,
                                     logic [BYTE_W-1:0] c);
    tok_t              t;
    logic [BYTE_W-1:0] want;
    logic [BYTE_W-1:0] digit;
    t     = tok;
    want  = (tok.len == '0) ? CH_P : CH_6;
    digit = c - CH_ZERO;
    if (tok.len >= LEN_W'(MAX_TOKEN_CHARS)) begin
      t.invalid = 1'b1;
    end else begin
      if (phase == PH_MAGIC) begin
        if (tok.len >= LEN_W'(2) || c != want) begin
          t.magic_ok = 1'b0;
        end
      end else if (!(c inside {[CH_ZERO:CH_NINE]})) begin
        t.invalid = 1'b1;
      end else begin
        t.value = (tok.value << 3) + (tok.value << 1) + TOK_W'(digit);
      end
      t.len = LEN_W'(tok.len + LEN_W'(1));
    end
    return t;
  endfunction

  function automatic logic [DIM_W-1:0] sat_dim(logic [TOK_W-1:0] v);
    logic [CMP_W-1:0] x;
    x = CMP_W'(v);
    return (x > DIM_SAT) ? DIM_W'(DIM_SAT) : DIM_W'(x);
  endfunction

endpackage

FILE: src/ppm_hdr_parse.sv
// Per-byte tokeniser and field judge holding the header parse state.
module ppm_hdr_parse
  import ppm_hdr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [BYTE_W-1:0] byte_i,
  output logic              res_valid_o,
  output res_t              res_o
);

  logic [PH_W-1:0]  phase_q, phase_d;
  logic             skip_q, skip_d;
  logic             cmnt_q, cmnt_d;
  tok_t             tok_q, tok_d;
  logic [DIM_W-1:0] held_w_q, held_w_d;
  logic [DIM_W-1:0] held_h_q, held_h_d;
  logic             advance;
  logic             restart;

  always_comb begin
    phase_d     = phase_q;
    skip_d      = skip_q;
    cmnt_d      = cmnt_q;
    tok_d       = tok_q;
    held_w_d    = held_w_q;
    held_h_d    = held_h_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    advance     = 1'b0;
    restart     = 1'b0;

    if (fire_i) begin
      if (!skip_q) begin
        if (is_space(byte_i)) begin
          skip_d = 1'b1;
        end else begin
          tok_d = take_char(tok_q, phase_q, byte_i);
        end
      end else if (cmnt_q) begin
        if (byte_i == CH_LF) begin
          cmnt_d = 1'b0;
        end
      end else if (is_space(byte_i)) begin
        skip_d = 1'b1;
      end else if (byte_i == CH_HASH) begin
        cmnt_d = 1'b1;
      end else begin
        case (phase_q)
          PH_MAGIC: begin
            if (!(tok_q.magic_ok && !tok_q.invalid && tok_q.len == LEN_W'(2))) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_BAD_MAGIC;
              restart      = 1'b1;
            end else begin
              advance = 1'b1;
            end
          end
          PH_WIDTH: begin
            if (tok_q.invalid) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_BAD_WIDTH;
              restart      = 1'b1;
            end else begin
              held_w_d = sat_dim(tok_q.value);
              advance  = 1'b1;
            end
          end
          PH_HEIGHT: begin
            if (tok_q.invalid) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_BAD_HEIGHT;
              restart      = 1'b1;
            end else begin
              held_h_d = sat_dim(tok_q.value);
              advance  = 1'b1;
            end
          end
          default: begin
            res_valid_o = 1'b1;
            restart     = 1'b1;
            if (tok_q.invalid || CMP_W'(tok_q.value) >= MAXVAL_LIMIT) begin
              res_o.status = ST_BAD_MAXVAL;
            end else begin
              res_o.status = ST_OK;
              res_o.width  = held_w_q;
              res_o.height = held_h_q;
              res_o.maxv   = MAXV_W'(CMP_W'(tok_q.value));
              res_o.pixel  = byte_i;
            end
          end
        endcase
      end
    end

    if (advance) begin
      phase_d = PH_W'(phase_q + PH_W'(1));
      skip_d  = 1'b0;
      tok_d   = take_char(TOK_CLEAR, PH_W'(phase_q + PH_W'(1)), byte_i);
    end
    if (restart) begin
      phase_d  = PH_MAGIC;
      skip_d   = 1'b0;
      cmnt_d   = 1'b0;
      tok_d    = TOK_CLEAR;
      held_w_d = '0;
      held_h_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC;
      skip_q   <= 1'b0;
      cmnt_q   <= 1'b0;
      tok_q    <= TOK_CLEAR;
      held_w_q <= '0;
      held_h_q <= '0;
    end else begin
      phase_q  <= phase_d;
      skip_q   <= skip_d;
      cmnt_q   <= cmnt_d;
      tok_q    <= tok_d;
      held_w_q <= held_w_d;
      held_h_q <= held_h_d;
    end
  end

endmodule

FILE: src/ppm_hdr_out.sv
// Result register with stall handling on the output channel.
module ppm_hdr_out
  import ppm_hdr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic out_stall_i,
  output logic ready_o,
  output logic out_valid_o,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q, res_d;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (ready_o) begin
      valid_d = load_i;
      if (load_i) begin
        res_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: src/ppm_hdr_parser_top.sv
// Top level of the binary PPM (P6) header parser.
// Takes one header byte per beat and reports, once the maxval token is closed by
// the first non-separator byte, the width, height, maxval and that first pixel
// byte with status 0, or on the first bad token a status code 1 to 4 with zero
// fields; '#' after whitespace starts a comment running to LF. One byte is taken
// every cycle unless the input side is stalled; a byte that closes the header is
// judged while it sits in the input register, and its result is loaded into the
// result register that drives the outputs. While the result register is full
// and stalled, a byte waiting in the input register stalls the input side.
module ppm_p6_header_parser_top
  import ppm_hdr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        header_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [16:0]       image_width_o,
  output logic [16:0]       image_height_o,
  output logic [15:0]       max_value_o,
  output logic [7:0]        first_pixel_byte_o
);

  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              ready;
  logic              fire;
  logic              res_valid;
  res_t              res;
  res_t              out_res;

  assign in_stall_o = in_valid_q && !ready;
  assign fire       = in_valid_q && ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= header_byte_i;
    end
  end

  ppm_hdr_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ppm_hdr_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign status_o           = out_res.status;
  assign image_width_o      = out_res.width;
  assign image_height_o     = out_res.height;
  assign max_value_o        = out_res.maxv;
  assign first_pixel_byte_o = out_res.pixel;

endmodule

FILE: src/ppm_hdr_checker.sv
// Port-level checker for the PPM P6 header parser, bound to the top level.
module ppm_hdr_checker
  import ppm_hdr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [16:0] image_width_o,
  input logic [16:0] image_height_o,
  input logic [15:0] max_value_o,
  input logic [7:0]  first_pixel_byte_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(image_width_o) && $stable(image_height_o)
      && $stable(max_value_o) && $stable(first_pixel_byte_o))
    else $error("stalled result beat changed");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_BAD_MAXVAL)
    else $error("status code out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> image_width_o == '0 && image_height_o == '0
      && max_value_o == '0 && first_pixel_byte_o == '0)
    else $error("error result carries non-zero fields");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

endmodule

bind ppm_p6_header_parser_top ppm_hdr_checker u_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .status_o           (status_o),
  .image_width_o      (image_width_o),
  .image_height_o     (image_height_o),
  .max_value_o        (max_value_o),
  .first_pixel_byte_o (first_pixel_byte_o)
);
